FILE: rtl/twc_pkg.sv
// ----------------------------------------------------------------------------
// twc_pkg
// Types, codes and constants shared by the receive-window clamper.
// ----------------------------------------------------------------------------
package twc_pkg;

	localparam int FLOW_ENTRIES_DEF = 1024;

	localparam logic [1:0] ACT_EGRESS = 2'd0;
	localparam logic [1:0] ACT_OPTION = 2'd1;
	localparam logic [1:0] ACT_LIMIT  = 2'd2;

	localparam logic [3:0] ST_PASSED        = 4'd0;
	localparam logic [3:0] ST_NO_LIMIT      = 4'd1;
	localparam logic [3:0] ST_LIMIT_ZERO    = 4'd2;
	localparam logic [3:0] ST_NO_SCALE      = 4'd3;
	localparam logic [3:0] ST_CLAMPED       = 4'd4;
	localparam logic [3:0] ST_SCALE_LEARNED = 4'd5;
	localparam logic [3:0] ST_IGNORED       = 4'd6;
	localparam logic [3:0] ST_OPT_ERROR     = 4'd7;
	localparam logic [3:0] ST_LIMIT_STORED  = 4'd8;
	localparam logic [3:0] ST_TABLE_FULL    = 4'd9;

	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [15:0] MIN_FRAME = 16'd54;
	localparam logic [7:0]  TCP_SYN   = 8'h02;
	localparam logic [3:0]  SCALE_MAX = 4'd14;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] own_addr;
		logic [31:0] peer_addr;
		logic [15:0] own_port;
		logic [15:0] peer_port;
		logic [15:0] window;
		logic [7:0]  tcp_flags;
		logic [15:0] ethertype;
		logic [7:0]  ip_protocol;
		logic [15:0] frame_length;
		logic [31:0] value;
		logic        option_valid;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] window_out;
		logic [3:0]  status;
	} out_beat_t;

	typedef struct packed {
		logic [95:0] key;
		logic        lim_ok;
		logic [31:0] limit;
		logic        sc_ok;
		logic [3:0]  scale;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_RD,
		S_CMP,
		S_EXEC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic cmp;
		logic inc;
		logic exec;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic direct;
		logic empty;
		logic match;
		logic last;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/twc_stream_if.sv
// ----------------------------------------------------------------------------
// twc_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface twc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/twc_ram.sv
// ----------------------------------------------------------------------------
// twc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module twc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/twc_datapath.sv
// ----------------------------------------------------------------------------
// twc_datapath
// Item register, flow table, slot scan index, fill count and result logic.
// ----------------------------------------------------------------------------
module twc_datapath #(
	parameter int FLOW_ENTRIES = twc_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  twc_pkg::cmd_t       cmd,
	output twc_pkg::sts_t       sts,
	input  twc_pkg::in_beat_t   in_data,
	twc_stream_if.source        out_ch
);
	import twc_pkg::*;

	localparam int AW = $clog2(FLOW_ENTRIES);
	localparam int CW = $clog2(FLOW_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(FLOW_ENTRIES);

	in_beat_t  item_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic      hit_q;
	out_beat_t res_q;
	out_beat_t out_q;
	logic      out_valid_q;

	entry_t    rd_entry;
	entry_t    wr_entry;
	logic [$bits(entry_t)-1:0] rdata;
	logic [95:0] key;
	logic      ipv4;
	logic      syn;
	logic      egress_ok;
	logic      opt_ok;
	logic      full;
	logic      direct;
	logic      we;
	logic [AW-1:0] waddr;
	logic [31:0] lim_sh;
	logic [15:0] lim_sat;
	logic [3:0]  scale_in;
	out_beat_t   res_d;

	assign key       = {item_q.own_addr, item_q.peer_addr,
			    item_q.own_port, item_q.peer_port};
	assign ipv4      = item_q.ethertype == ETH_IPV4;
	assign syn       = (item_q.tcp_flags & TCP_SYN) == TCP_SYN;
	assign egress_ok = ipv4 && item_q.ip_protocol == PROTO_TCP &&
			   item_q.frame_length >= MIN_FRAME;
	assign opt_ok    = ipv4 && syn && item_q.option_valid;
	assign full      = cnt_q == CNT_FULL;
	assign rd_entry  = entry_t'(rdata);

	always_comb begin
		unique case (item_q.action)
			ACT_EGRESS: direct = !egress_ok;
			ACT_OPTION: direct = !opt_ok;
			ACT_LIMIT:  direct = 1'b0;
			default:    direct = 1'b1;
		endcase
	end
	assign sts.direct   = direct;
	assign sts.empty    = cnt_q == '0;
	assign sts.match    = rd_entry.key == key;
	assign sts.last     = CW'(idx_q) + CW'(1) == cnt_q;
	assign sts.out_free = !out_valid_q || out_ch.ready;

	twc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(FLOW_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_entry),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign lim_sh   = rd_entry.limit >> rd_entry.scale;
	assign lim_sat  = (|lim_sh[31:16]) ? 16'hFFFF : lim_sh[15:0];
	assign scale_in = (item_q.value > 32'(SCALE_MAX)) ? SCALE_MAX : item_q.value[3:0];
	assign waddr    = hit_q ? idx_q : cnt_q[AW-1:0];
	assign we       = cmd.exec && !direct && item_q.action != ACT_EGRESS &&
			  (hit_q || !full);

	always_comb begin
		if (hit_q) begin
			wr_entry = rd_entry;
		end else begin
			wr_entry = '{key: key, lim_ok: 1'b0, limit: '0, sc_ok: 1'b0, scale: '0};
		end
		if (item_q.action == ACT_LIMIT) begin
			wr_entry.lim_ok = 1'b1;
			wr_entry.limit  = item_q.value;
		end else begin
			wr_entry.sc_ok = 1'b1;
			wr_entry.scale = scale_in;
		end
	end

	always_comb begin
		res_d.window_out = item_q.window;
		res_d.status     = ST_IGNORED;
		if (direct) begin
			if (item_q.action == ACT_OPTION && ipv4 && syn) begin
				res_d.status = ST_OPT_ERROR;
			end
		end else if (item_q.action == ACT_EGRESS) begin
			priority if (!hit_q || !rd_entry.lim_ok) begin
				res_d.status = ST_NO_LIMIT;
			end else if (rd_entry.limit == '0) begin
				res_d.status = ST_LIMIT_ZERO;
			end else if (!rd_entry.sc_ok) begin
				res_d.status = ST_NO_SCALE;
			end else if (lim_sat < item_q.window) begin
				res_d.window_out = lim_sat;
				res_d.status     = ST_CLAMPED;
			end else begin
				res_d.status = ST_PASSED;
			end
		end else if (!hit_q && full) begin
			res_d.status = ST_TABLE_FULL;
		end else if (item_q.action == ACT_LIMIT) begin
			res_d.status = ST_LIMIT_STORED;
		end else begin
			res_d.status = ST_SCALE_LEARNED;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else if (cmd.inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.cmp && sts.match) begin
				hit_q <= 1'b1;
			end
			if (we && !hit_q) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
endmodule

FILE: rtl/twc_ctrl.sv
// ----------------------------------------------------------------------------
// twc_ctrl
// Sequencer: accept, table scan, execute, hand off result.
// ----------------------------------------------------------------------------
module twc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  twc_pkg::sts_t sts,
	output twc_pkg::cmd_t cmd
);
	import twc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				state_d = S_CHK;
			end
			S_CHK: state_d = (sts.direct || sts.empty) ? S_EXEC : S_RD;
			S_RD:  state_d = S_CMP;
			S_CMP: state_d = (sts.match || sts.last) ? S_EXEC : S_RD;
			S_EXEC: state_d = S_DONE;
			S_DONE: if (sts.out_free) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == S_IDLE;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_CHK:  ;
			S_RD:   cmd.rd = 1'b1;
			S_CMP: begin
				cmd.cmp = 1'b1;
				cmd.inc = !sts.match && !sts.last;
			end
			S_EXEC: cmd.exec = 1'b1;
			S_DONE: cmd.push = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/tcp_receive_window_clamper.sv
// Sequence: an accepted item passes the check state, then goes to execute when no
// scan is needed, else reads filled slots in order until a match or the last one.
// Flow: one item at a time; a new beat is taken only once the result is handed off,
// so an output stall holds it. A scanned slot is one RAM read and one compare state.
// The next item is taken while a result waits.
// Reset: arst_n clears the fill count, sequencer and output valid; no clear pass.
// ----------------------------------------------------------------------------
// tcp_receive_window_clamper
// Per-flow TCP receive-window clamp with a fill-ordered flow table.
// ----------------------------------------------------------------------------
module tcp_receive_window_clamper #(
	parameter int FLOW_ENTRIES = twc_pkg::FLOW_ENTRIES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	twc_stream_if.sink   in_ch,
	twc_stream_if.source out_ch
);
	import twc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	twc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	twc_datapath #(
		.FLOW_ENTRIES(FLOW_ENTRIES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_data (in_ch.data),
		.out_ch  (out_ch)
	);
endmodule

FILE: rtl/twc_checker.sv
// ----------------------------------------------------------------------------
// twc_checker
// Port-level checks for the receive-window clamper.
// ----------------------------------------------------------------------------
module twc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input twc_pkg::out_beat_t out_data
);
	import twc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out beat changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_TABLE_FULL)
		else $error("status code out of range");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");
endmodule

bind tcp_receive_window_clamper twc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
